// ===== sv/bps_pkg.sv =====
package bps_pkg;

   localparam int CW  = 17;   // vector component into normalize
   localparam int UW  = 16;   // unit component, Q2.14
   localparam int SSW = 35;   // sum of squares
   localparam int SQW = 51;   // sqrt working width
   localparam int RTW = 25;   // sqrt result / stages
   localparam int QW  = 15;   // unit quotient bits / stages
   localparam int DNW = 40;   // normalize dividend
   localparam int DW  = 15;   // clamped dot, unsigned Q1.14
   localparam int PW  = 17;   // power, Q.16
   localparam int NW  = 57;   // attenuation numerator
   localparam int TW  = 25;   // term, quotient bits / stages
   localparam int RGW = 48;   // widest register
   localparam int UNIT_SHIFT = 22;
   localparam int LEN_SHIFT  = 16;
   localparam int DIF_SHIFT  = 18;

   localparam logic [DW-1:0] ONE_Q14  = 15'd16384;
   localparam logic [PW-1:0] ONE_Q16  = 17'd65536;
   localparam logic [TW-1:0] TERM_CAP = 25'd16777216;

   localparam logic [2:0] REG_LIGHT0    = 3'd0;
   localparam logic [2:0] REG_LIGHT1    = 3'd1;
   localparam logic [2:0] REG_EYE       = 3'd2;
   localparam logic [2:0] REG_INTENSITY = 3'd3;
   localparam logic [2:0] REG_AMBIENT   = 3'd4;
   localparam logic [2:0] REG_SPECULAR  = 3'd5;
   localparam logic [2:0] REG_SHININESS = 3'd6;

   typedef logic signed [CW-1:0] comp_type;
   typedef logic signed [UW-1:0] unit_type;

   function automatic logic [DW-1:0] clamped_dot(input unit_type a0, input unit_type a1,
                                                 input unit_type a2, input unit_type b0,
                                                 input unit_type b1, input unit_type b2);
      logic signed [33:0] s;
      logic [19:0]        q;
      s = 34'(a0) * 34'(b0) + 34'(a1) * 34'(b1) + 34'(a2) * 34'(b2);
      q = s[33:14];
      if (s <= 0) begin
         return '0;
      end
      if (q > 20'(ONE_Q14)) begin
         return ONE_Q14;
      end
      return q[DW-1:0];
   endfunction

endpackage

// ===== sv/bps_unitize.sv =====
module bps_unitize
   import bps_pkg::*;
#(
   parameter int NV = 1,
   parameter int SW = 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           adv,
   input  logic           in_valid,
   input  comp_type       vec_in [NV][3],
   input  logic [SW-1:0]  side_in,
   output logic           out_valid,
   output unit_type       unit_out [NV][3],
   output logic [SSW-1:0] ssq_out [NV],
   output logic [SW-1:0]  side_out
);

   localparam int LAT = 3 + RTW + QW;

   logic            vld_ff [LAT];
   logic [SW-1:0]   sd_ff [LAT];
   logic [2*CW-1:0] sq_ff [NV][3];
   comp_type        ca_ff [NV][3];
   logic [SSW-1:0]  s_ff [NV];
   comp_type        cb_ff [NV][3];
   logic [SQW-1:0]  rt_rem_ff [NV][RTW];
   logic [SQW-1:0]  rt_res_ff [NV][RTW];
   comp_type        rt_c_ff [NV][RTW][3];
   logic [SSW-1:0]  rt_s_ff [NV][RTW];
   logic [DNW-1:0]  dv_rem_ff [NV][3][QW];
   logic [QW-1:0]   dv_q_ff [NV][3][QW];
   logic            dv_neg_ff [NV][3][QW];
   logic [RTW-1:0]  dv_l_ff [NV][QW];
   logic [SSW-1:0]  dv_s_ff [NV][QW];
   unit_type        unit_ff [NV][3];
   logic [SSW-1:0]  ss_ff [NV];

   function automatic logic [2*SQW-1:0] rt_step(input logic [SQW-1:0] rem,
                                                input logic [SQW-1:0] res,
                                                input int unsigned sh);
      logic [SQW-1:0] one_v;
      logic [SQW-1:0] trial;
      one_v = SQW'(1) << sh;
      trial = res + one_v;
      if (rem >= trial) begin
         return {rem - trial, (res >> 1) + one_v};
      end
      return {rem, res >> 1};
   endfunction

   function automatic logic [DNW+QW-1:0] dv_step(input logic [DNW-1:0] rem,
                                                 input logic [QW-1:0] q,
                                                 input logic [RTW-1:0] len,
                                                 input int unsigned sh);
      logic [DNW-1:0] sub;
      sub = DNW'(len) << sh;
      if (rem >= sub) begin
         return {rem - sub, q | (QW'(1) << sh)};
      end
      return {rem, q};
   endfunction

   function automatic logic [CW-1:0] abs_comp(input comp_type c);
      return c[CW-1] ? CW'(-c) : CW'(c);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < LAT; t++) begin
            vld_ff[t] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int t = 1; t < LAT; t++) begin
            vld_ff[t] <= vld_ff[t-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sd_ff[0] <= side_in;
         for (int t = 1; t < LAT; t++) begin
            sd_ff[t] <= sd_ff[t-1];
         end
         for (int v = 0; v < NV; v++) begin
            // squares and sum
            for (int i = 0; i < 3; i++) begin
               sq_ff[v][i] <= (2*CW)'(vec_in[v][i]) * (2*CW)'(vec_in[v][i]);
               ca_ff[v][i] <= vec_in[v][i];
               cb_ff[v][i] <= ca_ff[v][i];
            end
            s_ff[v] <= SSW'(sq_ff[v][0]) + SSW'(sq_ff[v][1]) + SSW'(sq_ff[v][2]);

            // length = sqrt(s << 16), two bits per stage
            {rt_rem_ff[v][0], rt_res_ff[v][0]} <=
               rt_step({s_ff[v], LEN_SHIFT'(0)}, '0, 2*(RTW-1));
            rt_s_ff[v][0] <= s_ff[v];
            for (int i = 0; i < 3; i++) begin
               rt_c_ff[v][0][i] <= cb_ff[v][i];
            end
            for (int k = 1; k < RTW; k++) begin
               {rt_rem_ff[v][k], rt_res_ff[v][k]} <=
                  rt_step(rt_rem_ff[v][k-1], rt_res_ff[v][k-1], 2*(RTW-1-k));
               rt_s_ff[v][k] <= rt_s_ff[v][k-1];
               for (int i = 0; i < 3; i++) begin
                  rt_c_ff[v][k][i] <= rt_c_ff[v][k-1][i];
               end
            end

            // |c| << 22 / length, one quotient bit per stage
            dv_l_ff[v][0] <= rt_res_ff[v][RTW-1][RTW-1:0];
            dv_s_ff[v][0] <= rt_s_ff[v][RTW-1];
            for (int i = 0; i < 3; i++) begin
               {dv_rem_ff[v][i][0], dv_q_ff[v][i][0]} <=
                  dv_step(DNW'(abs_comp(rt_c_ff[v][RTW-1][i])) << UNIT_SHIFT, '0,
                          rt_res_ff[v][RTW-1][RTW-1:0], QW-1);
               dv_neg_ff[v][i][0] <= rt_c_ff[v][RTW-1][i][CW-1];
            end
            for (int k = 1; k < QW; k++) begin
               dv_l_ff[v][k] <= dv_l_ff[v][k-1];
               dv_s_ff[v][k] <= dv_s_ff[v][k-1];
               for (int i = 0; i < 3; i++) begin
                  {dv_rem_ff[v][i][k], dv_q_ff[v][i][k]} <=
                     dv_step(dv_rem_ff[v][i][k-1], dv_q_ff[v][i][k-1],
                             dv_l_ff[v][k-1], QW-1-k);
                  dv_neg_ff[v][i][k] <= dv_neg_ff[v][i][k-1];
               end
            end

            // sign and zero-length fixup
            ss_ff[v] <= dv_s_ff[v][QW-1];
            for (int i = 0; i < 3; i++) begin
               if (dv_l_ff[v][QW-1] == '0) begin
                  unit_ff[v][i] <= '0;
               end else if (dv_neg_ff[v][i][QW-1]) begin
                  unit_ff[v][i] <= -UW'(dv_q_ff[v][i][QW-1]);
               end else begin
                  unit_ff[v][i] <= UW'(dv_q_ff[v][i][QW-1]);
               end
            end
         end
      end
   end

   assign out_valid = vld_ff[LAT-1];
   assign side_out  = sd_ff[LAT-1];
   assign unit_out  = unit_ff;
   assign ssq_out   = ss_ff;

endmodule

// ===== sv/blinn_phong_fragment_shading.sv =====
// Throughput: one transaction per cycle; every stage is registered and the
// whole pipeline advances whenever the output register is empty or taken.
// The two normalize pipelines (sqrt and divide, 43 stages each) and the
// 25-stage attenuation divider set the depth.
// Reset (synchronous, active high) clears all valid bits and loads the
// register defaults.
module blinn_phong_fragment_shading
   import bps_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [7:0]      req_base_red,
   input  logic [7:0]      req_base_green,
   input  logic [7:0]      req_base_blue,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_pos_z,
   input  logic signed [15:0] req_norm_x,
   input  logic signed [15:0] req_norm_y,
   input  logic signed [15:0] req_norm_z,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [7:0]      rsp_out_red,
   output logic [7:0]      rsp_out_green,
   output logic [7:0]      rsp_out_blue,
   input  logic            csr_write_enable,
   input  logic [2:0]      csr_index,
   input  logic [RGW-1:0]  csr_write_data
);

   localparam int NPW  = 8;
   localparam int NLN  = 8;
   localparam int ACCW = 28;

   typedef struct packed {
      logic [2:0][UW-1:0]  nrm;
      logic [1:0][DW-1:0]  ndl;
      logic [1:0][SSW-1:0] r2;
      logic [2:0][7:0]     base;
   } shade_type;

   logic [RGW-1:0] light0_ff, light1_ff, eye_ff;
   logic [15:0]    intensity_ff, ambient_ff, specular_ff;
   logic [7:0]     shininess_ff;

   logic adv;

   unit_type      pos_w [3];
   unit_type      nrm_w [3];
   logic [2:0][7:0] base_w;

   logic          p1_v_ff;
   comp_type      p1_vec_ff [4][3];
   logic [23:0]   p1_base_ff;

   logic          u1_v;
   unit_type      u1_unit [4][3];
   logic [SSW-1:0] u1_ssq [4];
   logic [23:0]   u1_base;

   logic          p3_v_ff;
   comp_type      hs_ff [2][3];
   shade_type     shd3_ff;

   logic          u2_v;
   unit_type      u2_unit [2][3];
   shade_type     u2_shd;

   logic          p5_v_ff;
   logic [DW-1:0] ndh_ff [2];
   shade_type     shd5_ff;

   logic          pw_v_ff [NPW];
   logic [PW-1:0] pw_x_ff [2][NPW];
   logic [PW-1:0] pw_r_ff [2][NPW];
   shade_type     pw_sd_ff [NPW];

   logic          n1_v_ff;
   logic [31:0]   ksi_ff;
   logic [24:0]   p255_ff [2];
   logic [23:0]   bi_ff [3];
   logic [DW-1:0] nd_ff [2];
   logic [SSW-1:0] r2n1_ff [2];

   logic          n2_v_ff;
   logic [NW-1:0] num_ff [NLN];
   logic [SSW-1:0] r2n2_ff [2];

   logic          at_v_ff [TW];
   logic [NW-1:0] at_rem_ff [NLN][TW];
   logic [TW-1:0] at_q_ff [NLN][TW];
   logic          at_sat_ff [NLN][TW];
   logic          at_zero_ff [NLN][TW];
   logic [SSW-1:0] at_r2_ff [2][TW];

   logic          tv_ff;
   logic [TW-1:0] term_ff [NLN];

   logic          rsp_valid_ff;
   logic [7:0]    out_ff [3];
   logic [ACCW-1:0] acc_w [3];
   logic [ACCW-1:0] amb_w;

   function automatic logic [NW+TW-1:0] at_step(input logic [NW-1:0] rem,
                                                input logic [TW-1:0] q,
                                                input logic [SSW-1:0] r2,
                                                input int unsigned sh);
      logic [NW+1:0] sub;
      sub = (NW+2)'(r2) << sh;
      if ({2'b0, rem} >= sub) begin
         return {rem - sub[NW-1:0], q | (TW'(1) << sh)};
      end
      return {rem, q};
   endfunction

   function automatic logic [2*PW-1:0] pw_step(input logic [PW-1:0] x,
                                               input logic [PW-1:0] r,
                                               input logic e_bit);
      logic [2*PW-1:0] xx;
      logic [2*PW-1:0] rx;
      xx = (2*PW)'(x) * (2*PW)'(x);
      rx = (2*PW)'(r) * (2*PW)'(x);
      return {xx[PW+15:16], e_bit ? rx[PW+15:16] : r};
   endfunction

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         light0_ff    <= 48'd21990568104960;
         light1_ff    <= 48'd335604736;
         eye_ff       <= 48'd10995116277760;
         intensity_ff <= 16'd500;
         ambient_ff   <= 16'd3277;
         specular_ff  <= 16'd52017;
         shininess_ff <= 8'd150;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_LIGHT0:    light0_ff    <= csr_write_data;
            REG_LIGHT1:    light1_ff    <= csr_write_data;
            REG_EYE:       eye_ff       <= csr_write_data;
            REG_INTENSITY: intensity_ff <= csr_write_data[15:0];
            REG_AMBIENT:   ambient_ff   <= csr_write_data[15:0];
            REG_SPECULAR:  specular_ff  <= csr_write_data[15:0];
            REG_SHININESS: shininess_ff <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      pos_w[0] = req_pos_x;
      pos_w[1] = req_pos_y;
      pos_w[2] = req_pos_z;
      nrm_w[0] = req_norm_x;
      nrm_w[1] = req_norm_y;
      nrm_w[2] = req_norm_z;
      base_w   = {req_base_blue, req_base_green, req_base_red};
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p5_v_ff <= 1'b0;
         n1_v_ff <= 1'b0;
         n2_v_ff <= 1'b0;
         tv_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int t = 0; t < NPW; t++) begin
            pw_v_ff[t] <= 1'b0;
         end
         for (int t = 0; t < TW; t++) begin
            at_v_ff[t] <= 1'b0;
         end
      end else if (adv) begin
         p1_v_ff <= req_valid;
         p3_v_ff <= u1_v;
         p5_v_ff <= u2_v;
         pw_v_ff[0] <= p5_v_ff;
         for (int t = 1; t < NPW; t++) begin
            pw_v_ff[t] <= pw_v_ff[t-1];
         end
         n1_v_ff <= pw_v_ff[NPW-1];
         n2_v_ff <= n1_v_ff;
         at_v_ff[0] <= n2_v_ff;
         for (int t = 1; t < TW; t++) begin
            at_v_ff[t] <= at_v_ff[t-1];
         end
         tv_ff <= at_v_ff[TW-1];
         rsp_valid_ff <= tv_ff;
      end
   end

   // vectors to normalize: normal, to eye, to light 0, to light 1
   always_ff @(posedge clock) begin
      if (adv) begin
         p1_base_ff <= base_w;
         for (int i = 0; i < 3; i++) begin
            p1_vec_ff[0][i] <= CW'(nrm_w[i]);
            p1_vec_ff[1][i] <= CW'(signed'(eye_ff[16*i +: 16])) - CW'(pos_w[i]);
            p1_vec_ff[2][i] <= CW'(signed'(light0_ff[16*i +: 16])) - CW'(pos_w[i]);
            p1_vec_ff[3][i] <= CW'(signed'(light1_ff[16*i +: 16])) - CW'(pos_w[i]);
         end
      end
   end

   bps_unitize #(
      .NV (4),
      .SW (24)
   ) u_unit_a (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (p1_v_ff),
      .vec_in    (p1_vec_ff),
      .side_in   (p1_base_ff),
      .out_valid (u1_v),
      .unit_out  (u1_unit),
      .ssq_out   (u1_ssq),
      .side_out  (u1_base)
   );

   // half vector sums and n.l
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < 3; i++) begin
               hs_ff[k][i] <= CW'(u1_unit[1][i]) + CW'(u1_unit[2+k][i]);
            end
            shd3_ff.ndl[k] <= clamped_dot(u1_unit[0][0], u1_unit[0][1], u1_unit[0][2],
                                          u1_unit[2+k][0], u1_unit[2+k][1],
                                          u1_unit[2+k][2]);
            shd3_ff.r2[k] <= u1_ssq[2+k];
         end
         for (int i = 0; i < 3; i++) begin
            shd3_ff.nrm[i] <= u1_unit[0][i];
         end
         shd3_ff.base <= u1_base;
      end
   end

   bps_unitize #(
      .NV (2),
      .SW ($bits(shade_type))
   ) u_unit_h (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (p3_v_ff),
      .vec_in    (hs_ff),
      .side_in   (shd3_ff),
      .out_valid (u2_v),
      .unit_out  (u2_unit),
      .ssq_out   (),
      .side_out  (u2_shd)
   );

   // n.h
   always_ff @(posedge clock) begin
      if (adv) begin
         shd5_ff <= u2_shd;
         for (int k = 0; k < 2; k++) begin
            ndh_ff[k] <= clamped_dot(signed'(u2_shd.nrm[0]), signed'(u2_shd.nrm[1]),
                                     signed'(u2_shd.nrm[2]), u2_unit[k][0],
                                     u2_unit[k][1], u2_unit[k][2]);
         end
      end
   end

   // power by squaring, one exponent bit per stage
   always_ff @(posedge clock) begin
      if (adv) begin
         pw_sd_ff[0] <= shd5_ff;
         for (int t = 1; t < NPW; t++) begin
            pw_sd_ff[t] <= pw_sd_ff[t-1];
         end
         for (int k = 0; k < 2; k++) begin
            {pw_x_ff[k][0], pw_r_ff[k][0]} <=
               pw_step(PW'(ndh_ff[k]) << 2, ONE_Q16, shininess_ff[0]);
            for (int t = 1; t < NPW; t++) begin
               {pw_x_ff[k][t], pw_r_ff[k][t]} <=
                  pw_step(pw_x_ff[k][t-1], pw_r_ff[k][t-1], shininess_ff[t]);
            end
         end
      end
   end

   // numerators
   always_ff @(posedge clock) begin
      if (adv) begin
         ksi_ff <= 32'(specular_ff) * 32'(intensity_ff);
         for (int k = 0; k < 2; k++) begin
            p255_ff[k] <= 25'(pw_r_ff[k][NPW-1]) * 25'(255);
            nd_ff[k]   <= pw_sd_ff[NPW-1].ndl[k];
            r2n1_ff[k] <= pw_sd_ff[NPW-1].r2[k];
         end
         for (int c = 0; c < 3; c++) begin
            bi_ff[c] <= 24'(pw_sd_ff[NPW-1].base[c]) * 24'(intensity_ff);
         end

         for (int k = 0; k < 2; k++) begin
            r2n2_ff[k] <= r2n1_ff[k];
            num_ff[4*k] <= NW'(ksi_ff) * NW'(p255_ff[k]);
            for (int c = 0; c < 3; c++) begin
               num_ff[4*k+1+c] <= (NW'(bi_ff[c]) * NW'(nd_ff[k])) << DIF_SHIFT;
            end
         end
      end
   end

   // attenuation divide, one quotient bit per stage
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 2; k++) begin
            at_r2_ff[k][0] <= r2n2_ff[k];
            for (int t = 1; t < TW; t++) begin
               at_r2_ff[k][t] <= at_r2_ff[k][t-1];
            end
         end
         for (int j = 0; j < NLN; j++) begin
            {at_rem_ff[j][0], at_q_ff[j][0]} <= at_step(num_ff[j], '0, r2n2_ff[j/4], TW-1);
            at_sat_ff[j][0]  <= (num_ff[j] >> TW) >= NW'(r2n2_ff[j/4]);
            at_zero_ff[j][0] <= num_ff[j] == '0;
            for (int t = 1; t < TW; t++) begin
               {at_rem_ff[j][t], at_q_ff[j][t]} <=
                  at_step(at_rem_ff[j][t-1], at_q_ff[j][t-1], at_r2_ff[j/4][t-1], TW-1-t);
               at_sat_ff[j][t]  <= at_sat_ff[j][t-1];
               at_zero_ff[j][t] <= at_zero_ff[j][t-1];
            end
            if (at_zero_ff[j][TW-1]) begin
               term_ff[j] <= '0;
            end else if (at_sat_ff[j][TW-1] || at_q_ff[j][TW-1] > TERM_CAP) begin
               term_ff[j] <= TERM_CAP;
            end else begin
               term_ff[j] <= at_q_ff[j][TW-1];
            end
         end
      end
   end

   // sum both lights, ambient counted twice
   always_comb begin
      amb_w = ACCW'(ambient_ff) * ACCW'(255);
      for (int c = 0; c < 3; c++) begin
         acc_w[c] = (amb_w << 1) + ACCW'(term_ff[0]) + ACCW'(term_ff[1+c])
                  + ACCW'(term_ff[4]) + ACCW'(term_ff[5+c]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < 3; c++) begin
            out_ff[c] <= (acc_w[c][ACCW-1:16] > 12'd255) ? 8'd255 : acc_w[c][23:16];
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = out_ff[0];
   assign rsp_out_green = out_ff[1];
   assign rsp_out_blue  = out_ff[2];

endmodule

// ===== tb/sv/blinn_phong_fragment_shading_checker.sv =====
`timescale 1ns / 1ps
module blinn_phong_fragment_shading_checker
   import bps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [7:0]        req_base_red,
   input  logic [7:0]        req_base_green,
   input  logic [7:0]        req_base_blue,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_pos_z,
   input  logic signed [15:0] req_norm_x,
   input  logic signed [15:0] req_norm_y,
   input  logic signed [15:0] req_norm_z,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [7:0]        rsp_out_red,
   input  logic [7:0]        rsp_out_green,
   input  logic [7:0]        rsp_out_blue,
   input  logic              csr_write_enable,
   input  logic [2:0]        csr_index,
   input  logic [RGW-1:0]    csr_write_data,
   output int                error_count,
   output int                pending_count
);

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef longint vec3_type [3];

   localparam longint unsigned TERM_LIMIT = 64'd256 << 16;

   logic [47:0] light0_ff, light1_ff, eye_ff;
   logic [15:0] intensity_ff, ambient_ff, ks_ff;
   logic [7:0]  shine_ff;

   rgb_type expected_shades[$];

   function automatic longint unsigned isqrt(longint unsigned s);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned sum_squares(vec3_type c);
      return longint'(c[0] * c[0]) + longint'(c[1] * c[1]) + longint'(c[2] * c[2]);
   endfunction

   function automatic vec3_type normalize(vec3_type c);
      vec3_type u;
      longint unsigned len;
      len = isqrt(sum_squares(c) << 16);
      for (int i = 0; i < 3; i++)
         u[i] = (len == 0) ? 64'sd0 : (c[i] * 64'sd4194304) / longint'(len);
      return u;
   endfunction

   function automatic longint unsigned dot_clamp(vec3_type a, vec3_type b);
      longint s;
      longint unsigned q;
      s = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
      if (s <= 0) return 0;
      q = longint'(s) >> 14;
      return (q > 16384) ? 16384 : q;
   endfunction

   function automatic longint unsigned power_q16(longint unsigned q14, logic [7:0] e);
      longint unsigned x, r;
      x = q14 << 2;
      r = 65536;
      for (int i = 0; i < 8; i++) begin
         if (e[i]) r = (r * x) >> 16;
         x = (x * x) >> 16;
      end
      return r;
   endfunction

   function automatic longint unsigned attenuate(longint unsigned num, longint unsigned r2);
      longint unsigned t;
      if (num == 0) return 0;
      if (r2 == 0) return TERM_LIMIT;
      t = num / r2;
      return (t > TERM_LIMIT) ? TERM_LIMIT : t;
   endfunction

   function automatic vec3_type unpack_point(logic [47:0] p);
      vec3_type v;
      v[0] = longint'($signed(p[15:0]));
      v[1] = longint'($signed(p[31:16]));
      v[2] = longint'($signed(p[47:32]));
      return v;
   endfunction

   function automatic rgb_type shade_fragment(logic [7:0] br, logic [7:0] bg, logic [7:0] bb,
                                              vec3_type pos, vec3_type nrm);
      vec3_type n, eye, toeye, v, lp, d, l, hs, h;
      longint unsigned base [3];
      longint unsigned acc [3];
      longint unsigned r2, ndl, ndh, pw, amb, spec, dif, c;
      rgb_type res;
      base[0] = 64'(br); base[1] = 64'(bg); base[2] = 64'(bb);
      acc[0] = 0; acc[1] = 0; acc[2] = 0;
      n = normalize(nrm);
      eye = unpack_point(eye_ff);
      for (int i = 0; i < 3; i++) toeye[i] = eye[i] - pos[i];
      v = normalize(toeye);
      for (int k = 0; k < 2; k++) begin
         lp = unpack_point(k == 0 ? light0_ff : light1_ff);
         for (int i = 0; i < 3; i++) d[i] = lp[i] - pos[i];
         r2 = sum_squares(d);
         l = normalize(d);
         for (int i = 0; i < 3; i++) hs[i] = v[i] + l[i];
         h = normalize(hs);
         ndl = dot_clamp(n, l);
         ndh = dot_clamp(n, h);
         pw = power_q16(ndh, shine_ff);
         amb = 255 * longint'(ambient_ff);
         spec = attenuate(255 * longint'(ks_ff) * longint'(intensity_ff) * pw, r2);
         for (int i = 0; i < 3; i++) begin
            dif = attenuate((base[i] * longint'(intensity_ff) * ndl * 4) << 16, r2);
            acc[i] += amb + dif + spec;
         end
      end
      c = acc[0] >> 16; res.red   = (c > 255) ? 8'd255 : c[7:0];
      c = acc[1] >> 16; res.green = (c > 255) ? 8'd255 : c[7:0];
      c = acc[2] >> 16; res.blue  = (c > 255) ? 8'd255 : c[7:0];
      return res;
   endfunction

   assign pending_count = expected_shades.size();

   always @(posedge clock) begin
      vec3_type pos, nrm;
      rgb_type want, got;
      if (reset) begin
         light0_ff    <= 48'd21990568104960;
         light1_ff    <= 48'd335604736;
         eye_ff       <= 48'd10995116277760;
         intensity_ff <= 16'd500;
         ambient_ff   <= 16'd3277;
         ks_ff        <= 16'd52017;
         shine_ff     <= 8'd150;
         error_count  <= 0;
         expected_shades.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_LIGHT0:    light0_ff    <= csr_write_data[47:0];
               REG_LIGHT1:    light1_ff    <= csr_write_data[47:0];
               REG_EYE:       eye_ff       <= csr_write_data[47:0];
               REG_INTENSITY: intensity_ff <= csr_write_data[15:0];
               REG_AMBIENT:   ambient_ff   <= csr_write_data[15:0];
               REG_SPECULAR:  ks_ff        <= csr_write_data[15:0];
               REG_SHININESS: shine_ff     <= csr_write_data[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            pos[0] = longint'(req_pos_x); pos[1] = longint'(req_pos_y);
            pos[2] = longint'(req_pos_z);
            nrm[0] = longint'(req_norm_x); nrm[1] = longint'(req_norm_y);
            nrm[2] = longint'(req_norm_z);
            expected_shades.push_back(shade_fragment(req_base_red, req_base_green,
                                                     req_base_blue, pos, nrm));
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_out_red, rsp_out_green, rsp_out_blue};
            if (expected_shades.size() == 0) begin
               if (error_count < 10)
                  $display("ERROR: unexpected transaction rgb=%0d,%0d,%0d",
                           got.red, got.green, got.blue);
               error_count <= error_count + 1;
            end else begin
               want = expected_shades.pop_front();
               if (want !== got) begin
                  if (error_count < 10)
                     $display("ERROR: rgb expected %0d,%0d,%0d got %0d,%0d,%0d",
                              want.red, want.green, want.blue,
                              got.red, got.green, got.blue);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

// ===== tb/sv/blinn_phong_fragment_shading_tb.sv =====
`timescale 1ns / 1ps
module blinn_phong_fragment_shading_tb
   import bps_pkg::*;
();

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [7:0] req_base_red = 0, req_base_green = 0, req_base_blue = 0;
   logic signed [15:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic signed [15:0] req_norm_x = 0, req_norm_y = 0, req_norm_z = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [7:0] rsp_out_red, rsp_out_green, rsp_out_blue;
   logic csr_write_enable = 0;
   logic [2:0] csr_index = REG_LIGHT0;
   logic [RGW-1:0] csr_write_data = 0;
   int error_count, pending_count;
   bit no_idle = 0;
   int quiet_cycles = 0;
   int rsp_stall = 0;

   always #6 clock = ~clock;

   blinn_phong_fragment_shading dut (.*);

   blinn_phong_fragment_shading_checker checker_i (.*);

   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ready <= 0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
         rsp_stall <= $urandom_range(0, 4);
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= 5000) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [47:0] point(int x, int y, int z);
      return {16'(z), 16'(y), 16'(x)};
   endfunction

   task automatic send_fragment(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                                logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
      req_valid <= 1;
      req_base_red <= r; req_base_green <= g; req_base_blue <= b;
      req_pos_x <= px; req_pos_y <= py; req_pos_z <= pz;
      req_norm_x <= nx; req_norm_y <= ny; req_norm_z <= nz;
      forever begin
         @(negedge clock);
         if (req_ready) break;
         @(posedge clock);
      end
      @(posedge clock);
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic drain;
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (140) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [47:0] data);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   task automatic configure(logic [47:0] l0, logic [47:0] l1, logic [47:0] eye,
                            logic [15:0] inten, logic [15:0] amb, logic [15:0] ks,
                            logic [7:0] shine);
      write_reg(REG_LIGHT0, l0);
      write_reg(REG_LIGHT1, l1);
      write_reg(REG_EYE, eye);
      write_reg(REG_INTENSITY, 48'(inten));
      write_reg(REG_AMBIENT, 48'(amb));
      write_reg(REG_SPECULAR, 48'(ks));
      write_reg(REG_SHININESS, 48'(shine));
      csr_write_enable <= 0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] rand_pos();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         default: return 16'($signed($urandom_range(0, 16'h4000)) - 32'sh2000);
      endcase
   endfunction

   function automatic logic [15:0] rand_norm();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 32768)) - 32'sd16384);
         default: return 16'($signed($urandom_range(0, 2000)) - 32'sd1000);
      endcase
   endfunction

   task automatic random_fragments(int count);
      repeat (count) begin
         send_fragment(8'($urandom), 8'($urandom), 8'($urandom),
                       rand_pos(), rand_pos(), rand_pos(),
                       rand_norm(), rand_norm(), rand_norm());
         if ($urandom_range(0, 199) == 0) begin
            req_valid <= 0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
      end
   endtask

   task automatic random_config;
      configure(48'({$urandom, $urandom}) & 48'h0000_1FFF_1FFF,
                point($urandom_range(0, 16'h2000) - 16'h1000,
                      $urandom_range(0, 16'h2000) - 16'h1000,
                      $urandom_range(0, 16'h2000) - 16'h1000),
                48'($urandom) | (48'($urandom) << 32),
                16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset configuration, directed fragments
      send_fragment(0, 0, 0, 0, 0, 0, 0, 0, 16384);
      send_fragment(255, 255, 255, 0, 0, 0, 0, 0, 16384);
      send_fragment(255, 128, 1, 16'h1400, 16'h1400, 16'h1400, 16384, 0, 0);
      send_fragment(200, 100, 50, 16'h0000, 16'h0000, 16'h0A00, 0, 0, 16384);
      send_fragment(255, 255, 255, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_fragment(255, 255, 255, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_fragment(90, 90, 90, 0, 0, 0, 0, 0, 0);
      send_fragment(10, 20, 30, 0, 0, 0, 16'h8000, 0, 0);
      send_fragment(255, 0, 255, 16'hEC00, 16'h1400, 0, 0, 16384, 0);
      send_fragment(77, 88, 99, 0, 16'h0100, 0, 11585, 11585, 0);
      send_fragment(255, 255, 255, 0, 0, 0, 9459, 9459, 9459);
      send_fragment(1, 2, 3, 16'h0100, 16'hFF00, 16'h0200, 0, 0, 16'hC000);
      drain();

      // all zero registers, shininess zero
      configure(48'h0, 48'h0, 48'h0, 16'h0, 16'h0, 16'h0, 8'h0);
      send_fragment(255, 255, 255, 0, 0, 0, 0, 0, 16384);
      send_fragment(255, 255, 255, 16'h0100, 0, 0, 16384, 0, 0);
      random_fragments(150);
      drain();

      // all registers at their maximum
      configure('1, '1, '1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_fragment(255, 255, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0);
      random_fragments(150);
      drain();

      // mid-scale scene, shininess one
      configure(point(16'h0800, 16'h0800, 16'h0800), point(16'hF800, 16'h0400, 0),
                point(0, 0, 16'h0400), 16'd50, 16'd2000, 16'd30000, 8'd1);
      random_fragments(400);
      drain();

      repeat (3) begin
         random_config();
         random_fragments(300);
         drain();
      end

      // far lights, strong intensity, no idling from here on
      configure(point(16'h7FFF, 16'h7FFF, 16'h7FFF), point(16'h8000, 16'h7FFF, 0),
                point(0, 0, 16'h7FFF), 16'hFFFF, 16'd3277, 16'd52017, 8'd150);
      no_idle = 1;
      random_fragments(300);
      req_valid <= 0;
      @(posedge clock);

      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== blinn_phong_fragment_shading.f =====
sv/bps_pkg.sv
sv/bps_unitize.sv
sv/blinn_phong_fragment_shading.sv
tb/sv/blinn_phong_fragment_shading_checker.sv
tb/sv/blinn_phong_fragment_shading_tb.sv
